FILE: rtl/htld_pkg.sv
// ----------------------------------------------------------------------------
// htld_pkg - shared types and constants for the tree load decoder
// Default sizes, byte codes, mode and status codes, and the queue word.
// ----------------------------------------------------------------------------
package htld_pkg;

  localparam int MAX_NODES_DEF   = 512;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] BYTE_INTERNAL = 8'h23;
  localparam logic [7:0] BYTE_LEFT     = 8'h30;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_DECODE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_READY   = 3'd1,
    ST_TABLE_FULL  = 3'd2,
    ST_AFTER_DONE  = 3'd3,
    ST_SINGLE_LEAF = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_STEP,
    OP_CLEAR
  } op_t;

  // flag: internal node for a load, go left for a step
  typedef struct packed {
    op_t        op;
    logic       flag;
    logic [7:0] data;
  } qword_t;

endpackage

FILE: rtl/htld_cmd_if.sv
// ----------------------------------------------------------------------------
// htld_cmd_if - command channel
// Carries one mode and one byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface htld_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] in_byte;

  modport source (output valid, output mode, output in_byte, input ready);
  modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

FILE: rtl/htld_res_if.sv
// ----------------------------------------------------------------------------
// htld_res_if - result channel
// Carries one decoded symbol and status per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface htld_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_valid;
  logic [2:0] status;
  logic       tree_ready;

  modport source (output valid, output symbol, output symbol_valid, output status,
                  output tree_ready, input ready);
  modport sink   (input valid, input symbol, input symbol_valid, input status,
                  input tree_ready, output ready);
endinterface

FILE: rtl/huffman_tree_load_decoder.sv
// Words are queued in front; the back end registers each result as it takes it.
// Throughput: one word per cycle while results are taken; a decode step is one
// read of the child table at the walk position, which is refetched every cycle.
// Reset clears the tree (empty, not ready), the queue and the result stage.
// The node table and pending stack hold no reset; only loaded entries are read.
// ----------------------------------------------------------------------------
// huffman_tree_load_decoder - preorder tree loader and code walker
// Front end queues classified words; back end builds and walks the tree.
// ----------------------------------------------------------------------------
module huffman_tree_load_decoder #(
  parameter int MAX_NODES   = htld_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = htld_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  htld_cmd_if.sink   cmd,
  htld_res_if.source res
);
  import htld_pkg::*;

  qword_t word;
  logic   word_valid;
  logic   word_ready;

  htld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .word       (word),
    .word_valid (word_valid),
    .word_ready (word_ready)
  );

  htld_back #(
    .MAX_NODES   (MAX_NODES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .word       (word),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .res        (res)
  );

  a_sym_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.symbol_valid |-> res.status == ST_OK && res.tree_ready)
    else $error("symbol emitted with bad status or no tree");

  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_NOT_READY |-> !res.tree_ready)
    else $error("not-ready status while tree complete");

  a_done_states: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status == ST_AFTER_DONE || res.status == ST_SINGLE_LEAF)
      |-> res.tree_ready)
    else $error("complete-tree status without a complete tree");

  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.symbol_valid |-> res.symbol == 8'd0)
    else $error("symbol not zero without a leaf");

endmodule

FILE: rtl/htld_front.sv
// ----------------------------------------------------------------------------
// htld_front - command intake
// Classifies each command word and holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
module htld_front (
  input  logic            clk,
  input  logic            rst,
  htld_cmd_if.sink        cmd,
  output htld_pkg::qword_t word,
  output logic            word_valid,
  input  logic            word_ready
);
  import htld_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  qword_t          entries [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [FW-1:0]   fill;
  qword_t          classified;
  logic            push;
  logic            pop;

  always_comb begin
    classified.data = cmd.in_byte;
    classified.flag = 1'b0;
    unique case (cmd.mode)
      MODE_LOAD: begin
        classified.op   = OP_LOAD;
        classified.flag = (cmd.in_byte == BYTE_INTERNAL);
      end
      MODE_DECODE: begin
        classified.op   = OP_STEP;
        classified.flag = (cmd.in_byte == BYTE_LEFT);
      end
      MODE_CLEAR: classified.op = OP_CLEAR;
      default:    classified.op = OP_NOP;
    endcase
  end

  assign cmd.ready  = (fill != FW'(QUEUE_DEPTH));
  assign push       = cmd.valid && cmd.ready;
  assign word_valid = (fill != '0);
  assign pop        = word_valid && word_ready;
  assign word       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule

FILE: rtl/htld_back.sv
// ----------------------------------------------------------------------------
// htld_back - tree builder and walker
// Builds the node table from preorder bytes and walks it one step per word.
// Each parent stores its children's links: a leaf child holds its symbol,
// an internal child its node index, so one table read serves one step.
// ----------------------------------------------------------------------------
module htld_back #(
  parameter int MAX_NODES   = htld_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = htld_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  htld_pkg::qword_t word,
  input  logic             word_valid,
  output logic             word_ready,
  htld_res_if.source       res
);
  import htld_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = (IW > 8) ? IW : 8;

  // {leaf, symbol or node index}
  typedef logic [VW:0] link_t;
  // {left child set, node index}
  typedef logic [IW:0] pend_t;

  link_t left_mem  [MAX_NODES];
  link_t right_mem [MAX_NODES];
  pend_t stack_mem [STACK_DEPTH];

  // tree state
  logic [NW-1:0] nodes_used, nodes_used_next;
  logic [CW-1:0] pend_count, pend_count_next;
  logic [IW-1:0] walk, walk_next;
  logic          done, done_next;
  logic          root_leaf, root_leaf_next;
  logic [IW-1:0] top_node, top_node_next;
  logic          top_left_set, top_left_set_next;
  pend_t         below;
  link_t         cur_left;
  link_t         cur_right;

  // table and stack writes
  logic          lwe, rwe;
  logic [IW-1:0] node_waddr;
  link_t         link_wdata;
  logic          swe;
  logic [SW-1:0] swaddr, sraddr;
  pend_t         swdata;
  logic [CW-1:0] cnt_m1, cnt_m2;

  // result
  logic          out_valid;
  logic [7:0]    symbol;
  logic          symbol_valid;
  status_t       status;
  logic [7:0]    sym_next;
  logic          symv_next;
  status_t       st;

  logic          fire;
  logic [IW-1:0] idx;
  logic          attach;
  logic          pop;
  logic [CW:0]   after;
  link_t         child;

  assign word_ready = !out_valid || res.ready;
  assign fire       = word_valid && word_ready;
  assign idx        = nodes_used[IW-1:0];
  assign cnt_m1     = pend_count - CW'(1);
  assign cnt_m2     = pend_count_next - CW'(2);
  assign sraddr     = cnt_m2[SW-1:0];

  always_comb begin
    nodes_used_next   = nodes_used;
    pend_count_next   = pend_count;
    walk_next         = walk;
    done_next         = done;
    root_leaf_next    = root_leaf;
    top_node_next     = top_node;
    top_left_set_next = top_left_set;
    lwe               = 1'b0;
    rwe               = 1'b0;
    node_waddr        = top_node;
    link_wdata        = {!word.flag, word.flag ? VW'(idx) : VW'(word.data)};
    swe               = 1'b0;
    swaddr            = cnt_m1[SW-1:0];
    swdata            = {1'b1, top_node};
    sym_next          = 8'd0;
    symv_next         = 1'b0;
    st                = ST_OK;
    attach            = (nodes_used != '0) && (pend_count != '0);
    pop               = attach && top_left_set;
    after             = {1'b0, pend_count} - (CW+1)'(pop) + (CW+1)'(word.flag);
    child             = word.flag ? cur_left : cur_right;

    if (fire) begin
      unique case (word.op)
        OP_LOAD: begin
          if (done) begin
            st = ST_AFTER_DONE;
          end else if (nodes_used >= NW'(MAX_NODES) || after > (CW+1)'(STACK_DEPTH)) begin
            st = ST_TABLE_FULL;
          end else begin
            if (nodes_used == '0) begin
              root_leaf_next = !word.flag;
            end
            if (attach) begin
              if (top_left_set) begin
                rwe = 1'b1;
              end else begin
                lwe               = 1'b1;
                top_left_set_next = 1'b1;
              end
            end
            if (pop && word.flag) begin
              // closed parent replaced by the new internal node
              top_node_next     = idx;
              top_left_set_next = 1'b0;
            end else if (pop) begin
              pend_count_next   = cnt_m1;
              top_node_next     = below[IW-1:0];
              top_left_set_next = below[IW];
            end else if (word.flag) begin
              // push: spill the current top below the new one
              swe               = (pend_count != '0);
              pend_count_next   = pend_count + CW'(1);
              top_node_next     = idx;
              top_left_set_next = 1'b0;
            end
            nodes_used_next = nodes_used + NW'(1);
            done_next       = (pend_count_next == '0);
          end
        end
        OP_STEP: begin
          if (!done) begin
            st = ST_NOT_READY;
          end else if (root_leaf) begin
            st = ST_SINGLE_LEAF;
          end else if (child[VW]) begin
            sym_next  = child[7:0];
            symv_next = 1'b1;
            walk_next = '0;
          end else begin
            walk_next = child[IW-1:0];
          end
        end
        OP_CLEAR: begin
          pend_count_next = '0;
          nodes_used_next = '0;
          walk_next       = '0;
          done_next       = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // node table: read at the next walk position, write-first on a clash
  always_ff @(posedge clk) begin
    if (lwe) begin
      left_mem[node_waddr] <= link_wdata;
    end
    if (lwe && node_waddr == walk_next) begin
      cur_left <= link_wdata;
    end else begin
      cur_left <= left_mem[walk_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rwe) begin
      right_mem[node_waddr] <= link_wdata;
    end
    if (rwe && node_waddr == walk_next) begin
      cur_right <= link_wdata;
    end else begin
      cur_right <= right_mem[walk_next];
    end
  end

  // pending stack below the top, prefetching the entry under the next top
  always_ff @(posedge clk) begin
    if (swe) begin
      stack_mem[swaddr] <= swdata;
    end
    if (swe && swaddr == sraddr) begin
      below <= swdata;
    end else begin
      below <= stack_mem[sraddr];
    end
  end

  always_ff @(posedge clk) begin
    top_node     <= top_node_next;
    top_left_set <= top_left_set_next;
    root_leaf    <= root_leaf_next;
    if (fire) begin
      symbol       <= sym_next;
      symbol_valid <= symv_next;
      status       <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= '0;
      pend_count <= '0;
      walk       <= '0;
      done       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      nodes_used <= nodes_used_next;
      pend_count <= pend_count_next;
      walk       <= walk_next;
      done       <= done_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // tree_ready is captured with the word that produced it
  logic tree_ready;
  always_ff @(posedge clk) begin
    if (fire) begin
      tree_ready <= done_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.symbol       = symbol;
  assign res.symbol_valid = symbol_valid;
  assign res.status       = status;
  assign res.tree_ready   = tree_ready;

endmodule

FILE: bench/huffman_tree_load_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_load_decoder_tb - self-checking bench for the tree load decoder
// Loads code trees in preorder and walks them, checking each result word against
// a tree model held here or a directed row's want, idling randomly on both sides.
// ----------------------------------------------------------------------------
module huffman_tree_load_decoder_tb;
  import htld_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1000;
  localparam int LONG_HOLD    = 200;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    status_t    status;
    logic       tree_ready;
  } outcome_t;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] data;
    bit         typed;
    outcome_t   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  htld_cmd_if cmd ();
  htld_res_if res ();

  huffman_tree_load_decoder u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tree held by the bench
  bit         tn_leaf  [MAX_NODES_DEF];
  logic [7:0] tn_sym   [MAX_NODES_DEF];
  int         tn_left  [MAX_NODES_DEF];
  int         tn_right [MAX_NODES_DEF];
  int         par_node      [STACK_DEPTH_DEF];
  bit         par_left_done [STACK_DEPTH_DEF];
  int         par_count;
  int         node_count;
  int         walk_at;
  bit         tree_complete;

  outcome_t pending_outcomes [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int mismatches    = 0;
  int words_sent    = 0;
  int symbols_seen  = 0;
  int errors_seen   = 0;

  dir_row_t directed_rows [23] = '{
    '{MODE_DECODE, 8'h30, 1'b1, '{8'h00, 1'b0, ST_NOT_READY, 1'b0}},
    '{MODE_UNUSED, 8'hFF, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_CLEAR,  8'h00, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_LOAD,   8'h41, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b1}},
    '{MODE_DECODE, 8'h30, 1'b1, '{8'h00, 1'b0, ST_SINGLE_LEAF, 1'b1}},
    '{MODE_LOAD,   8'h23, 1'b1, '{8'h00, 1'b0, ST_AFTER_DONE, 1'b1}},
    '{MODE_CLEAR,  8'hFF, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_LOAD,   8'h23, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_LOAD,   8'h00, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_LOAD,   8'h23, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_LOAD,   8'hFF, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_LOAD,   8'h30, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b1}},
    '{MODE_DECODE, 8'h30, 1'b0, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_DECODE, 8'h31, 1'b0, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_DECODE, 8'h30, 1'b0, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_DECODE, 8'hFF, 1'b0, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_DECODE, 8'h00, 1'b0, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_DECODE, 8'h2F, 1'b0, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_LOAD,   8'h41, 1'b1, '{8'h00, 1'b0, ST_AFTER_DONE, 1'b1}},
    '{MODE_UNUSED, 8'h5A, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b1}},
    '{MODE_DECODE, 8'h30, 1'b0, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_CLEAR,  8'h00, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{MODE_DECODE, 8'h31, 1'b1, '{8'h00, 1'b0, ST_NOT_READY, 1'b0}}
  };

  function automatic outcome_t decode_outcome(input logic [1:0] op_mode,
                                              input logic [7:0] data);
    outcome_t o;
    bit       internal;
    int       after;
    int       top;
    int       idx;
    int       nxt;
    o = '{8'h00, 1'b0, ST_OK, 1'b0};
    internal = (data == BYTE_INTERNAL);
    case (op_mode)
      MODE_LOAD: begin
        if (tree_complete) begin
          o.status = ST_AFTER_DONE;
        end else if (node_count >= MAX_NODES_DEF) begin
          o.status = ST_TABLE_FULL;
        end else begin
          after = par_count;
          if (node_count != 0 && par_count != 0 && par_left_done[par_count - 1]) after--;
          if (internal) after++;
          if (after > STACK_DEPTH_DEF) begin
            o.status = ST_TABLE_FULL;
          end else begin
            idx = node_count;
            tn_leaf[idx]  = !internal;
            tn_sym[idx]   = internal ? 8'h00 : data;
            tn_left[idx]  = 0;
            tn_right[idx] = 0;
            // attach to the newest parent still short of a child
            if (node_count != 0 && par_count != 0) begin
              top = par_count - 1;
              if (!par_left_done[top]) begin
                tn_left[par_node[top]] = idx;
                par_left_done[top] = 1'b1;
              end else begin
                tn_right[par_node[top]] = idx;
                par_count = top;
              end
            end
            if (internal && par_count < STACK_DEPTH_DEF) begin
              par_node[par_count]      = idx;
              par_left_done[par_count] = 1'b0;
              par_count++;
            end
            node_count++;
            tree_complete = (par_count == 0);
          end
        end
      end
      MODE_DECODE: begin
        if (!tree_complete) begin
          o.status = ST_NOT_READY;
        end else if (tn_leaf[0]) begin
          o.status = ST_SINGLE_LEAF;
        end else begin
          nxt = (data == BYTE_LEFT) ? tn_left[walk_at] : tn_right[walk_at];
          if (tn_leaf[nxt]) begin
            o.symbol       = tn_sym[nxt];
            o.symbol_valid = 1'b1;
            walk_at        = 0;
          end else begin
            walk_at = nxt;
          end
        end
      end
      MODE_CLEAR: begin
        par_count     = 0;
        node_count    = 0;
        walk_at       = 0;
        tree_complete = 1'b0;
      end
      default: ;
    endcase
    o.tree_ready = tree_complete;
    return o;
  endfunction

  function automatic logic [7:0] leaf_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255, 0));
    if (b == BYTE_INTERNAL) b = ~b;
    return b;
  endfunction

  function automatic logic [7:0] code_char(input int left_pct);
    if ($urandom_range(99, 0) < left_pct) return BYTE_LEFT;
    return 8'($urandom_range(255, 0));
  endfunction

  // tree and code bytes show up often in the noise
  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(3, 0))
      0: return BYTE_INTERNAL;
      1: return BYTE_LEFT;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 82; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 82; end
      default: begin send_idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // valid stays high after a word goes in unless a gap or drain follows
  task automatic send_word(input logic [1:0] op_mode, input logic [7:0] data,
                           input bit typed = 1'b0, input outcome_t want = '0);
    outcome_t predicted;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.mode    <= op_mode;
    cmd.in_byte <= data;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predicted = decode_outcome(op_mode, data);
    pending_outcomes.push_back(typed ? want : predicted);
    if (op_mode != MODE_UNUSED) words_sent++;
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // cut < 0 sends the whole tree, else stops after cut words or at the tree's end
  task automatic load_random_tree(input int internals, input int cut);
    int slots;
    int spare;
    int sent;
    slots = 1;
    spare = internals;
    sent  = 0;
    while (slots > 0 && sent != cut) begin
      if (spare > 0 && (slots == 1 || $urandom_range(2, 0) != 0)) begin
        send_word(MODE_LOAD, BYTE_INTERNAL);
        slots++;
        spare--;
      end else begin
        send_word(MODE_LOAD, leaf_byte());
        slots--;
      end
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("word with nothing expected, status", int'(res.status), 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (res.symbol !== want.symbol)
          report_mismatch("symbol", int'(res.symbol), int'(want.symbol));
        if (res.symbol_valid !== want.symbol_valid)
          report_mismatch("symbol_valid", int'(res.symbol_valid),
                          int'(want.symbol_valid));
        if (res.status !== want.status)
          report_mismatch("status", int'(res.status), int'(want.status));
        if (res.tree_ready !== want.tree_ready)
          report_mismatch("tree_ready", int'(res.tree_ready), int'(want.tree_ready));
        if (want.symbol_valid) symbols_seen++;
        if (want.status != ST_OK) errors_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int seg;
    int pick;
    int k;
    int target;
    cmd.valid   <= 1'b0;
    cmd.mode    <= MODE_LOAD;
    cmd.in_byte <= 8'h00;
    for (int i = 0; i < MAX_NODES_DEF; i++) begin
      tn_leaf[i]  = 1'b0;
      tn_sym[i]   = 8'h00;
      tn_left[i]  = 0;
      tn_right[i] = 0;
    end
    par_count     = 0;
    node_count    = 0;
    walk_at       = 0;
    tree_complete = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_idling(0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].mode, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].want);
    drain();

    // longest chain the stack takes, one internal too many, then leaves
    // until the node table runs out
    send_word(MODE_CLEAR, 8'h00);
    repeat (STACK_DEPTH_DEF + 1) send_word(MODE_LOAD, BYTE_INTERNAL);
    repeat (STACK_DEPTH_DEF + 1) send_word(MODE_LOAD, leaf_byte());
    send_word(MODE_DECODE, BYTE_LEFT);
    drain();

    // deep left-leaning tree, walked mostly leftwards
    set_idling(3);
    send_word(MODE_CLEAR, 8'($urandom_range(255, 0)));
    repeat (100) send_word(MODE_LOAD, BYTE_INTERNAL);
    repeat (101) send_word(MODE_LOAD, leaf_byte());
    repeat (200) send_word(MODE_DECODE, code_char(85));
    drain();

    target = words_sent + RANDOM_WORDS;
    seg = 0;
    while (words_sent < target) begin
      set_idling((seg / 6) % 4);
      if (seg == 10) begin
        // sender keeps offering while the result side is held off
        send_idle_pct = 0;
        hold_requests++;
      end
      pick = $urandom_range(99, 0);
      k = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
      if (pick < 70) begin
        if ($urandom_range(9, 0) != 0) send_word(MODE_CLEAR, 8'($urandom_range(255, 0)));
        load_random_tree(k, -1);
        repeat ($urandom_range(40, 4)) begin
          case ($urandom_range(19, 0))
            0: send_word(MODE_UNUSED, 8'($urandom_range(255, 0)));
            1: send_word(MODE_LOAD, noisy_byte());
            default: send_word(MODE_DECODE, code_char(50));
          endcase
        end
      end else if (pick < 85) begin
        send_word(MODE_CLEAR, 8'($urandom_range(255, 0)));
        load_random_tree(k, $urandom_range(2 * k, 0));
        repeat ($urandom_range(6, 1))
          send_word($urandom_range(1, 0) ? MODE_DECODE : MODE_UNUSED, noisy_byte());
        if ($urandom_range(1, 0)) send_word(MODE_CLEAR, 8'($urandom_range(255, 0)));
      end else begin
        repeat ($urandom_range(10, 3)) send_word(2'($urandom_range(3, 0)), noisy_byte());
      end
      if (seg % 25 == 24) drain();
      seg++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d words over %0d random segments: %0d symbols decoded, %0d error statuses",
             words_sent, seg, symbols_seen, errors_seen);
    $display("Mismatches: %0d, words still expected: %0d", mismatches,
             pending_outcomes.size());
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
